// ----- sv/spq_pkg.sv -----
package spq_pkg;

    localparam int TAG_W    = 16;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ENQUEUED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DEQUEUED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t new_entry;
    } cell_ctl_t;

endpackage

// ----- sv/spq_if.sv -----
interface spq_req_if;
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [spq_pkg::TAG_W-1:0]  entry_tag;
    logic [spq_pkg::PRIO_W-1:0] priority_req;

    modport source (output valid, func, entry_tag, priority_req, input ready);
    modport sink   (input valid, func, entry_tag, priority_req, output ready);
endinterface

interface spq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [spq_pkg::STATUS_W-1:0] status;
    logic [spq_pkg::TAG_W-1:0]    out_tag;
    logic [spq_pkg::PRIO_W-1:0]   out_priority;
    logic [spq_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, status, out_tag, out_priority, occupancy, input ready);
    modport sink   (input valid, status, out_tag, out_priority, occupancy, output ready);
endinterface

// ----- sv/spq_cell.sv -----
module spq_cell (
    input  logic               clk,
    input  spq_pkg::cell_ctl_t ctl,
    input  logic               occupied,
    input  logic               left_take,
    input  spq_pkg::entry_t    left_entry,
    input  spq_pkg::entry_t    right_entry,
    output logic               take,
    output spq_pkg::entry_t    entry
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // Insert point: first free cell or first cell of strictly lower severity.
    assign take  = !occupied || (entry_reg.prio < ctl.new_entry.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.enq && take)
        begin
            entry_next = left_take ? left_entry : ctl.new_entry;
        end
        else if (ctl.deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- sv/stable_priority_queue.sv -----
// Stable priority queue of DEPTH entries, built as a row of shift cells.
// req channel: func (0 enqueue, 1 dequeue), entry_tag, priority_req.
// rsp channel: status, out_tag, out_priority, occupancy; one rsp beat per
// req beat, in order.
// An enqueue lands behind every stored entry of equal or higher severity;
// a dequeue returns the front entry (highest severity, oldest among equals).
// Every cell compares its own severity with the incoming one in parallel and
// shifts toward the back on insert or toward the front on removal.
// The rsp beat is valid the cycle after the req beat is taken.
// Throughput: one beat per cycle while rsp.ready is high; req.ready drops
// only while a finished beat sits in the output register and rsp is stalled.
// Reset empties the queue (count to zero) and drops the output valid;
// cell contents are not cleared and are never read before being written.
// Enqueue on a full queue returns status full, dequeue on an empty queue
// returns status empty; neither changes the stored entries.
module stable_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic                         out_valid_reg;
    logic [spq_pkg::STATUS_W-1:0] status_reg;
    logic [spq_pkg::STATUS_W-1:0] status_next;
    logic [spq_pkg::TAG_W-1:0]    tag_reg;
    logic [spq_pkg::TAG_W-1:0]    tag_next;
    logic [spq_pkg::PRIO_W-1:0]   prio_reg;
    logic [spq_pkg::PRIO_W-1:0]   prio_next;
    logic [spq_pkg::OCC_W-1:0]    occ_reg;

    logic               fire;
    logic               full;
    logic               empty;
    logic               sorted_ok;
    spq_pkg::cell_ctl_t ctl;
    spq_pkg::entry_t    entries [DEPTH];
    logic [DEPTH-1:0]   takes;
    logic [DEPTH-1:0]   occupied;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);

    assign ctl.enq           = fire && (req.func == spq_pkg::OP_ENQ) && !full;
    assign ctl.deq           = fire && (req.func == spq_pkg::OP_DEQ) && !empty;
    assign ctl.new_entry.tag  = req.entry_tag;
    assign ctl.new_entry.prio = req.priority_req;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        spq_pkg::entry_t left_e;
        spq_pkg::entry_t right_e;
        logic            left_t;

        assign occupied[i] = (CW'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign left_t = 1'b0;
            assign left_e = ctl.new_entry;
        end
        else
        begin : g_mid
            assign left_t = takes[i-1];
            assign left_e = entries[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_e = entries[i];
        end
        else
        begin : g_inner
            assign right_e = entries[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .occupied    (occupied[i]),
            .left_take   (left_t),
            .left_entry  (left_e),
            .right_entry (right_e),
            .take        (takes[i]),
            .entry       (entries[i])
        );
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = spq_pkg::ST_ENQUEUED;
        tag_next    = '0;
        prio_next   = '0;
        unique case (req.func)
            spq_pkg::OP_ENQ:
            begin
                if (full)
                begin
                    status_next = spq_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            spq_pkg::OP_DEQ:
            begin
                if (empty)
                begin
                    status_next = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    status_next = spq_pkg::ST_DEQUEUED;
                    tag_next    = entries[0].tag;
                    prio_next   = entries[0].prio;
                    count_next  = count_reg - CW'(1);
                end
            end
            default:
            begin
                status_next = spq_pkg::ST_ENQUEUED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg <= status_next;
            tag_reg    <= tag_next;
            prio_reg   <= prio_next;
            occ_reg    <= spq_pkg::OCC_W'(count_next);
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.out_tag      = tag_reg;
    assign rsp.out_priority = prio_reg;
    assign rsp.occupancy    = occ_reg;

    always_comb
    begin
        sorted_ok = 1'b1;
        for (int i = 0; i + 1 < DEPTH; i++)
        begin
            if (occupied[i+1] && (entries[i].prio < entries[i+1].prio))
            begin
                sorted_ok = 1'b0;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("count exceeds depth");

    a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.enq |=> count_reg == $past(count_reg) + CW'(1))
        else $error("enqueue did not grow count");

    a_empty_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (req.func == spq_pkg::OP_DEQ) && empty |=>
        rsp.valid && (rsp.status == spq_pkg::ST_EMPTY) && (count_reg == '0))
        else $error("empty dequeue mishandled");

    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        sorted_ok)
        else $error("queue order broken");

endmodule
